// ===== sv/lprf_pkg.sv =====
package lprf_pkg;

   localparam int LEN_W        = 6;
   localparam int BYTE_W       = 8;
   localparam int CAP_W        = 6;
   localparam int FREE_BYTES_W = 11;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;

   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_POP   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_FULL       = 3'd1,
      STATUS_EMPTY      = 3'd2,
      STATUS_DROPPED    = 3'd3,
      STATUS_INCOMPLETE = 3'd4
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [BYTE_W-1:0]         out_byte;
      logic                      byte_valid;
      logic                      last;
      logic [FREE_BYTES_W-1:0]   free_bytes;
      logic                      is_empty;
   } rsp_type;

endpackage

// ===== sv/length_prefixed_record_fifo.sv =====
// Byte ring buffer that holds variable-length records, each stored as a
// length header followed by its payload bytes.
// The request channel carries one word per command: the kind in req_tuser
// (begin, data, pop, clear) and length, payload byte and read capacity in
// req_tdata. The response channel returns status, a payload byte, the free
// byte count and an empty flag in rsp_tdata, the byte-valid flag in
// rsp_tuser, and marks the final response of a command with rsp_tlast.
// Begin, data, clear and refused pops each give a single response, which
// appears in the output register on the next cycle, so byte pushes run at
// one word per cycle while the output is not stalled. A pop reads the
// header and then streams one payload byte per cycle out of the ring
// memory, which has one read port; the request side is held until the
// last byte is delivered. The memory's output register serves as a skid
// stage, so a stall on rsp_tready pauses the stream without losing a byte;
// a new request is taken only when the output register is free or being emptied.
// Reset empties the buffer at once; the ring memory needs no clearing pass.
module length_prefixed_record_fifo
   import lprf_pkg::*;
   #(parameter int BUFFER_BYTES = 1024,
     parameter int HEADER_BYTES = 8,
     parameter int MAX_RECORD   = 63)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  req_tvalid,
    output logic                  req_tready,
    // record_length [5:0], data_byte [13:6], capacity [19:14], zeros above
    input  logic [REQ_DATA_W-1:0] req_tdata,
    // kind [1:0]
    input  logic [1:0]            req_tuser,
    output logic                  rsp_tvalid,
    input  logic                  rsp_tready,
    // status [2:0], out_byte [10:3], free_bytes [21:11], is_empty [22], zero [23]
    output logic [RSP_DATA_W-1:0] rsp_tdata,
    // byte_valid [0]
    output logic                  rsp_tuser,
    output logic                  rsp_tlast);

   localparam int PTR_W  = $clog2(BUFFER_BYTES);
   localparam int FREE_W = $clog2(BUFFER_BYTES + 1);
   localparam int SUM_W  = PTR_W + 8;
   localparam int CMP_W  = FREE_W + 8;
   localparam logic [6:0] HDR_LEN = 7'(HEADER_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_STREAM
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rp_ff, rp_in, wp_ff, wp_in, raddr_ff, raddr_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [LEN_W-1:0]  pending_ff, pending_in;
   logic              dropping_ff, dropping_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [LEN_W-1:0]  issue_left_ff, issue_left_in;
   logic [LEN_W-1:0]  deliver_left_ff, deliver_left_in;
   logic              rd_hold_ff, rd_hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we, ram_re;
   logic [PTR_W-1:0]  ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   kind_type          req_kind;
   logic [LEN_W-1:0]  req_len;
   logic [BYTE_W-1:0] req_byte;
   logic [CAP_W-1:0]  req_cap;

   logic              out_space, req_fire, load_out, re_stream;
   logic [LEN_W-1:0]  hdr_len, pop_count;
   logic [6:0]        pop_total;
   logic [CMP_W-1:0]  free_sum;
   logic [PTR_W-1:0]  first_addr;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(BUFFER_BYTES - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   // The step never exceeds the ring size, so one conditional subtract wraps.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [6:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(n);
      if (s >= SUM_W'(BUFFER_BYTES)) begin
         s = s - SUM_W'(BUFFER_BYTES);
      end
      return PTR_W'(s);
   endfunction

   function automatic rsp_type make_rsp(input status_type st,
                                        input logic [BYTE_W-1:0] b,
                                        input logic valid,
                                        input logic lst,
                                        input logic [FREE_W-1:0] free);
      rsp_type r;
      r.status     = st;
      r.out_byte   = b;
      r.byte_valid = valid;
      r.last       = lst;
      r.free_bytes = FREE_BYTES_W'(free);
      r.is_empty   = (free == FREE_W'(BUFFER_BYTES));
      return r;
   endfunction

   lprf_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata));

   assign req_kind = kind_type'(req_tuser);
   assign req_len  = req_tdata[5:0];
   assign req_byte = req_tdata[13:6];
   assign req_cap  = req_tdata[19:14];

   assign out_space  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_space;
   assign req_fire   = req_tvalid && req_tready;

   // Header decode: lengths up to 63 fit in the low header byte, so only the
   // low byte is written and read; the upper header bytes are left unwritten.
   assign hdr_len   = (ram_rdata > BYTE_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                        : ram_rdata[LEN_W-1:0];
   assign pop_count = (hdr_len < cap_ff) ? hdr_len : cap_ff;
   assign pop_total = 7'(hdr_len) + HDR_LEN;
   assign free_sum  = (CMP_W'(free_ff) + CMP_W'(pop_total) > CMP_W'(BUFFER_BYTES))
                      ? CMP_W'(BUFFER_BYTES) : CMP_W'(free_ff) + CMP_W'(pop_total);
   assign first_addr = wrap_add(rp_ff, HDR_LEN);

   // The memory read register holds a fetched byte until the output takes it.
   assign load_out  = (state_ff == ST_STREAM) && rd_hold_ff && out_space;
   assign re_stream = (state_ff == ST_STREAM) && (issue_left_ff != '0) &&
                      (!rd_hold_ff || load_out);

   always_comb begin
      state_in        = state_ff;
      rp_in           = rp_ff;
      wp_in           = wp_ff;
      raddr_in        = raddr_ff;
      free_in         = free_ff;
      pending_in      = pending_ff;
      dropping_in     = dropping_ff;
      cap_in          = cap_ff;
      issue_left_in   = issue_left_ff;
      deliver_left_in = deliver_left_ff;
      rd_hold_in      = rd_hold_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_in          = rsp_ff;
      ram_we          = 1'b0;
      ram_waddr       = wp_ff;
      ram_wdata       = req_byte;
      ram_re          = 1'b0;
      ram_raddr       = rp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  KIND_BEGIN: begin
                     if (pending_ff != '0) begin
                        rsp_in = make_rsp(STATUS_INCOMPLETE, '0, 1'b0, 1'b1, free_ff);
                     end else if (req_len > LEN_W'(MAX_RECORD) ||
                                  CMP_W'(free_ff) < CMP_W'(req_len) + CMP_W'(HDR_LEN)) begin
                        dropping_in = 1'b1;
                        rsp_in = make_rsp(STATUS_FULL, '0, 1'b0, 1'b1, free_ff);
                     end else begin
                        ram_we      = 1'b1;
                        ram_wdata   = BYTE_W'(req_len);
                        wp_in       = wrap_add(wp_ff, HDR_LEN);
                        free_in     = FREE_W'(CMP_W'(free_ff) - CMP_W'(req_len)
                                              - CMP_W'(HDR_LEN));
                        pending_in  = req_len;
                        dropping_in = 1'b0;
                        rsp_in = make_rsp(STATUS_OK, '0, 1'b0, 1'b1, free_in);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  KIND_DATA: begin
                     if (dropping_ff || pending_ff == '0) begin
                        rsp_in = make_rsp(STATUS_DROPPED, '0, 1'b0, 1'b1, free_ff);
                     end else begin
                        ram_we     = 1'b1;
                        wp_in      = wrap_inc(wp_ff);
                        pending_in = pending_ff - LEN_W'(1);
                        rsp_in = make_rsp(STATUS_OK, '0, 1'b0, 1'b1, free_ff);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  KIND_POP: begin
                     if (free_ff >= FREE_W'(BUFFER_BYTES)) begin
                        rsp_in = make_rsp(STATUS_EMPTY, '0, 1'b0, 1'b1, free_ff);
                        rsp_valid_in = 1'b1;
                     end else if (pending_ff != '0) begin
                        rsp_in = make_rsp(STATUS_INCOMPLETE, '0, 1'b0, 1'b1, free_ff);
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = rp_ff;
                        cap_in    = req_cap;
                        state_in  = ST_HDR;
                     end
                  end
                  KIND_CLEAR: begin
                     rp_in        = '0;
                     wp_in        = '0;
                     free_in      = FREE_W'(BUFFER_BYTES);
                     pending_in   = '0;
                     dropping_in  = 1'b0;
                     rsp_in = make_rsp(STATUS_OK, '0, 1'b0, 1'b1, free_in);
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HDR: begin
            if (pop_count == '0) begin
               // Nothing to emit: wait for the output, then free the record.
               if (out_space) begin
                  rp_in        = wrap_add(rp_ff, pop_total);
                  free_in      = FREE_W'(free_sum);
                  rsp_in       = make_rsp(STATUS_OK, '0, 1'b0, 1'b1, free_in);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rp_in           = wrap_add(rp_ff, pop_total);
               free_in         = FREE_W'(free_sum);
               ram_re          = 1'b1;
               ram_raddr       = first_addr;
               raddr_in        = wrap_inc(first_addr);
               issue_left_in   = pop_count - LEN_W'(1);
               deliver_left_in = pop_count;
               rd_hold_in      = 1'b1;
               state_in        = ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (re_stream) begin
               ram_re        = 1'b1;
               ram_raddr     = raddr_ff;
               raddr_in      = wrap_inc(raddr_ff);
               issue_left_in = issue_left_ff - LEN_W'(1);
               rd_hold_in    = 1'b1;
            end else if (load_out) begin
               rd_hold_in = 1'b0;
            end
            if (load_out) begin
               rsp_in = make_rsp(STATUS_OK, ram_rdata, 1'b1,
                                 deliver_left_ff == LEN_W'(1), free_ff);
               rsp_valid_in    = 1'b1;
               deliver_left_in = deliver_left_ff - LEN_W'(1);
               if (deliver_left_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rp_ff           <= '0;
         wp_ff           <= '0;
         free_ff         <= FREE_W'(BUFFER_BYTES);
         pending_ff      <= '0;
         dropping_ff     <= 1'b0;
         issue_left_ff   <= '0;
         deliver_left_ff <= '0;
         rd_hold_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rp_ff           <= rp_in;
         wp_ff           <= wp_in;
         free_ff         <= free_in;
         pending_ff      <= pending_in;
         dropping_ff     <= dropping_in;
         issue_left_ff   <= issue_left_in;
         deliver_left_ff <= deliver_left_in;
         rd_hold_ff      <= rd_hold_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      raddr_ff <= raddr_in;
      cap_ff   <= cap_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.is_empty, rsp_ff.free_bytes, rsp_ff.out_byte,
                        rsp_ff.status};
   assign rsp_tuser  = rsp_ff.byte_valid;
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ===== sv/lprf_ram.sv =====
module lprf_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 1024)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
